// ----- rtl/core/dnd_pkg.sv -----
// Shared constants, types and the controller/datapath command and status
// bundles for the Delannoy number core. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dnd_pkg;

    // largest grid dimension handled; larger requests saturate to it
    localparam int MAX_DIM     = 255;
    localparam int STORE_DEPTH = MAX_DIM + 1;
    localparam int DIM_W       = $clog2(STORE_DEPTH);
    localparam int IN_W        = 8;
    localparam int HALF_W      = 64;
    localparam int VAL_W       = 2 * HALF_W;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_ROW,
        S_CELL,
        S_DONE
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic row_start;
        logic calc;
        logic out_load;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic zero_dim;
        logic col_last;
        logic row_last;
        logic out_space;
    } t_sts;

endpackage

`default_nettype wire

// ----- rtl/core/dnd_ifs.sv -----
// Valid/ready channel interfaces for request and result beats.
// Depends on dnd_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface dnd_in_if;
    logic                      valid;
    logic                      ready;
    logic [dnd_pkg::IN_W-1:0]  rows;
    logic [dnd_pkg::IN_W-1:0]  cols;

    modport source (output valid, output rows, output cols, input ready);
    modport sink   (input valid, input rows, input cols, output ready);
endinterface

interface dnd_out_if;
    logic                        valid;
    logic                        ready;
    logic [dnd_pkg::HALF_W-1:0]  value_low;
    logic [dnd_pkg::HALF_W-1:0]  value_high;
    logic                        overflow;

    modport source (output valid, output value_low, output value_high,
                    output overflow, input ready);
    modport sink   (input valid, input value_low, input value_high,
                    input overflow, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/dnd_ctrl.sv -----
// Sequencer for the Delannoy core: walks rows and cells, issues commands
// to dnd_dpath. Depends on dnd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dnd_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire dnd_pkg::t_sts i_sts,
    output dnd_pkg::t_cmd      o_cmd
);

    dnd_pkg::t_state r_state;
    dnd_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dnd_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dnd_pkg::S_IDLE: begin
                if (i_in_valid) n_state = dnd_pkg::S_ROW;
            end
            dnd_pkg::S_ROW: begin
                if (i_sts.zero_dim) n_state = dnd_pkg::S_DONE;
                else                n_state = dnd_pkg::S_CELL;
            end
            dnd_pkg::S_CELL: begin
                if (i_sts.col_last) begin
                    if (i_sts.row_last) n_state = dnd_pkg::S_DONE;
                    else                n_state = dnd_pkg::S_ROW;
                end
            end
            dnd_pkg::S_DONE: begin
                if (i_sts.out_space) n_state = dnd_pkg::S_IDLE;
            end
            default: n_state = dnd_pkg::S_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            dnd_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            dnd_pkg::S_ROW: begin
                o_cmd.row_start = !i_sts.zero_dim;
            end
            dnd_pkg::S_CELL: begin
                o_cmd.calc = 1'b1;
            end
            dnd_pkg::S_DONE: begin
                o_cmd.out_load = i_sts.out_space;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/core/dnd_dpath.sv -----
// Datapath for the Delannoy core: row store memory, diagonal and left
// registers, 128-bit three-term adder, counters and result register.
// Depends on dnd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dnd_dpath (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire dnd_pkg::t_cmd              i_cmd,
    output dnd_pkg::t_sts                   o_sts,
    input  wire logic [dnd_pkg::IN_W-1:0]   i_rows,
    input  wire logic [dnd_pkg::IN_W-1:0]   i_cols,
    input  wire logic                       i_out_ready,
    output logic                            o_out_valid,
    output logic [dnd_pkg::HALF_W-1:0]      o_value_low,
    output logic [dnd_pkg::HALF_W-1:0]      o_value_high,
    output logic                            o_overflow
);

    localparam logic [dnd_pkg::VAL_W-1:0] VAL_ONE = dnd_pkg::VAL_W'(1);
    localparam logic [dnd_pkg::DIM_W-1:0] DIM_ONE = dnd_pkg::DIM_W'(1);

    // row store, one 128-bit entry per column
    logic [dnd_pkg::VAL_W-1:0] r_mem [dnd_pkg::STORE_DEPTH];
    logic [dnd_pkg::VAL_W-1:0] r_rd_data;
    logic [dnd_pkg::DIM_W-1:0] w_rd_addr;

    logic [dnd_pkg::DIM_W-1:0] r_m;
    logic [dnd_pkg::DIM_W-1:0] r_n;
    logic [dnd_pkg::DIM_W-1:0] r_row;
    logic [dnd_pkg::DIM_W-1:0] r_col;
    logic [dnd_pkg::VAL_W-1:0] r_diag;
    logic [dnd_pkg::VAL_W-1:0] r_left;
    logic                      r_ovf;
    logic                      r_out_valid;
    logic [dnd_pkg::VAL_W-1:0] r_out_value;
    logic                      r_out_ovf;

    logic [dnd_pkg::DIM_W-1:0] w_m_clamp;
    logic [dnd_pkg::DIM_W-1:0] w_n_clamp;
    logic [dnd_pkg::VAL_W-1:0] w_up;
    logic [dnd_pkg::VAL_W+1:0] w_sum;

    // saturate request dimensions to the store size
    always_comb begin
        if (32'(i_rows) > dnd_pkg::MAX_DIM) w_m_clamp = dnd_pkg::DIM_W'(dnd_pkg::MAX_DIM);
        else                                w_m_clamp = dnd_pkg::DIM_W'(i_rows);
        if (32'(i_cols) > dnd_pkg::MAX_DIM) w_n_clamp = dnd_pkg::DIM_W'(dnd_pkg::MAX_DIM);
        else                                w_n_clamp = dnd_pkg::DIM_W'(i_cols);
    end

    // row zero is all ones, so the first row takes its upper term as one
    assign w_up  = (r_row == DIM_ONE) ? VAL_ONE : r_rd_data;
    assign w_sum = {2'b00, w_up} + {2'b00, r_diag} + {2'b00, r_left};

    // read one column ahead of the cell being summed
    assign w_rd_addr = i_cmd.row_start ? DIM_ONE : (r_col + DIM_ONE);

    // row store ports
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[w_rd_addr];
        if (i_cmd.calc) begin
            r_mem[r_col] <= w_sum[dnd_pkg::VAL_W-1:0];
        end
    end

    // counters, diagonal and left terms
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_m   <= w_m_clamp;
            r_n   <= w_n_clamp;
            r_row <= DIM_ONE;
            r_col <= DIM_ONE;
        end
        if (i_cmd.row_start) begin
            r_col  <= DIM_ONE;
            r_diag <= VAL_ONE;
            r_left <= VAL_ONE;
        end
        if (i_cmd.calc) begin
            r_col  <= r_col + DIM_ONE;
            r_diag <= w_up;
            r_left <= w_sum[dnd_pkg::VAL_W-1:0];
            if (r_col == r_n) r_row <= r_row + DIM_ONE;
        end
    end

    // sticky overflow for the current request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovf <= 1'b0;
        end else if (i_cmd.load) begin
            r_ovf <= 1'b0;
        end else if (i_cmd.calc && (|w_sum[dnd_pkg::VAL_W+1:dnd_pkg::VAL_W-1])) begin
            r_ovf <= 1'b1;
        end
    end

    // result register, holds the beat until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_value <= o_sts.zero_dim ? VAL_ONE : r_left;
            r_out_ovf   <= r_ovf;
        end
    end

    // status to the controller
    always_comb begin
        o_sts.zero_dim  = (r_m == '0) || (r_n == '0);
        o_sts.col_last  = (r_col == r_n);
        o_sts.row_last  = (r_row == r_m);
        o_sts.out_space = !r_out_valid || i_out_ready;
    end

    assign o_out_valid  = r_out_valid;
    assign o_value_low  = r_out_value[dnd_pkg::HALF_W-1:0];
    assign o_value_high = r_out_value[dnd_pkg::VAL_W-1:dnd_pkg::HALF_W];
    assign o_overflow   = r_out_ovf;

    // cells never touch column zero and stay inside the requested grid
    a_cell_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.calc |-> (r_col != '0) && (r_col <= r_n) && (r_row <= r_m))
        else $error("cell outside requested grid");

    // every row begins at column one with unit diagonal and left terms
    a_row_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.row_start |=> (r_col == DIM_ONE) && (r_diag == VAL_ONE) && (r_left == VAL_ONE))
        else $error("row did not restart at column one");

    // a zero dimension yields one with no overflow
    a_zero_dim_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.out_load && o_sts.zero_dim) |=> (r_out_value == VAL_ONE) && !r_out_ovf)
        else $error("zero dimension result is not one");

    // a result is never loaded over one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten");

endmodule

`default_nettype wire

// ----- rtl/core/delannoy_number_dp_core.sv -----
// Delannoy number core: accepts (rows, cols) and returns D(rows, cols)
// modulo 2^128 with a signed-range overflow flag. The table is swept one cell
// per clock through a 256-entry row store using a single 128-bit three-term
// adder; each row begins with a row-start state that primes the store read.
// A request with a zero dimension skips the sweep and returns one.
// Dimensions above MAX_DIM saturate. The result sits in an output register,
// so the core returns to accepting beats as soon as the previous result has
// been loaded there.
// Depends on dnd_pkg, dnd_ifs, dnd_ctrl and dnd_dpath.
`timescale 1ns / 1ps
`default_nettype none

module delannoy_number_dp_core (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    dnd_in_if.sink    i_in,
    dnd_out_if.source o_out
);

    dnd_pkg::t_cmd w_cmd;
    dnd_pkg::t_sts w_sts;
    logic          w_in_ready;

    // sequencer
    dnd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // arithmetic, row store and result register
    dnd_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_rows       (i_in.rows),
        .i_cols       (i_in.cols),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .o_value_low  (o_out.value_low),
        .o_value_high (o_out.value_high),
        .o_overflow   (o_out.overflow)
    );

    assign i_in.ready = w_in_ready;

endmodule

`default_nettype wire
